// File: hw/rtl/plc_pkg.sv
// Shared types, constants and the register map decoder of the interrupt controller.
// It has no dependencies; plc_ctrl, plc_dpath and the core module import it.
package plc_pkg;

  localparam int NUM_SOURCES  = 64;
  localparam int NUM_CONTEXTS = 2;
  localparam int SRC_W        = $clog2(NUM_SOURCES);
  localparam int CNT_W        = $clog2(NUM_SOURCES + 1);
  localparam int CTX_W        = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
  localparam int OFF_W        = 26;

  // Register map.
  localparam logic [31:0] PEND_BASE  = 32'h0000_1000;
  localparam logic [31:0] PEND_SPAN  = 32'h0000_0008;
  localparam logic [31:0] EN_BASE    = 32'h0000_2000;
  localparam int          EN_SHIFT   = 7;
  localparam logic [31:0] CTX_BASE   = 32'h0020_0000;
  localparam int          CTX_SHIFT  = 12;
  localparam logic [11:0] SUB_THRESH = 12'h000;
  localparam logic [11:0] SUB_CLAIM  = 12'h004;

  // Item commands.
  localparam logic [1:0] CMD_READ  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_LEVEL = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_PRE_INIT,
    ST_PRE_RUN,
    ST_APPLY,
    ST_READ_WAIT,
    ST_POST_INIT,
    ST_POST_RUN,
    ST_RESP
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic srch_init;
    logic srch_run;
    logic apply;
    logic rd_prio;
    logic pend_capture;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic claim_read;
    logic prio_read;
    logic srch_done;
  } ctl_sts_t;

  typedef struct packed {
    logic             is_prio;
    logic [SRC_W-1:0] prio_idx;
    logic             is_pend;
    logic             pend_word;
    logic             is_en;
    logic [CTX_W-1:0] en_ctx;
    logic             en_word;
    logic             is_thr;
    logic             is_claim;
    logic [CTX_W-1:0] ctx;
  } dec_t;

  function automatic dec_t decode(input logic [OFF_W-1:0] off);
    dec_t        d;
    logic [31:0] off32;
    logic [31:0] rel_en;
    logic [31:0] c_en;
    logic [31:0] rel_ctx;
    logic [31:0] c_ctx;
    logic        in_ctx;
    off32   = {{(32-OFF_W){1'b0}}, off};
    rel_en  = off32 - EN_BASE;
    c_en    = rel_en >> EN_SHIFT;
    rel_ctx = off32 - CTX_BASE;
    c_ctx   = rel_ctx >> CTX_SHIFT;
    in_ctx  = (off32 >= CTX_BASE) && (c_ctx < 32'(NUM_CONTEXTS));
    d.is_prio   = off32 < 32'(4 * NUM_SOURCES);
    d.prio_idx  = off[SRC_W+1:2];
    d.is_pend   = (off32 >= PEND_BASE) && (off32 < PEND_BASE + PEND_SPAN);
    d.pend_word = off[2];
    d.is_en     = (off32 >= EN_BASE) && (off32 < CTX_BASE) &&
                  (c_en < 32'(NUM_CONTEXTS)) && (rel_en[6:2] < 5'd2);
    d.en_ctx    = c_en[CTX_W-1:0];
    d.en_word   = rel_en[2];
    d.is_thr    = in_ctx && (rel_ctx[11:0] == SUB_THRESH);
    d.is_claim  = in_ctx && (rel_ctx[11:0] == SUB_CLAIM);
    d.ctx       = c_ctx[CTX_W-1:0];
    return d;
  endfunction

endpackage

// File: hw/rtl/plc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// It has no dependencies.
module plc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/plc_ctrl.sv
// Sequencing state machine of the interrupt controller.
// Depends on plc_pkg for the state type and the command and status structs.
module plc_ctrl import plc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_stall,
  output logic     rsp_valid,
  input  logic     rsp_stall,
  input  ctl_sts_t sts,
  output ctl_cmd_t ctl
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:      if (req_valid) state_next = ST_DISPATCH;
      ST_DISPATCH:  state_next = sts.claim_read ? ST_PRE_INIT : ST_APPLY;
      ST_PRE_INIT:  state_next = ST_PRE_RUN;
      ST_PRE_RUN:   if (sts.srch_done) state_next = ST_APPLY;
      ST_APPLY:     state_next = sts.prio_read ? ST_READ_WAIT : ST_POST_INIT;
      ST_READ_WAIT: state_next = ST_POST_INIT;
      ST_POST_INIT: state_next = ST_POST_RUN;
      ST_POST_RUN:  if (sts.srch_done) state_next = ST_RESP;
      ST_RESP:      if (!rsp_stall) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    ctl          = '0;
    req_stall    = 1'b1;
    rsp_valid    = 1'b0;
    case (state)
      ST_IDLE: begin
        req_stall = 1'b0;
        ctl.latch = req_valid;
      end
      ST_PRE_INIT, ST_POST_INIT: ctl.srch_init = 1'b1;
      ST_PRE_RUN:   ctl.srch_run = 1'b1;
      ST_POST_RUN: begin
        ctl.srch_run     = 1'b1;
        ctl.pend_capture = sts.srch_done;
      end
      ST_APPLY:     ctl.apply = 1'b1;
      ST_READ_WAIT: ctl.rd_prio = 1'b1;
      ST_RESP:      rsp_valid = 1'b1;
      default: begin
        req_stall = 1'b1;
      end
    endcase
  end

endmodule

// File: hw/rtl/plc_dpath.sv
// Datapath of the interrupt controller: register file, priority RAM and serial search.
// Depends on plc_pkg and instantiates plc_ram for the source priorities.
module plc_dpath import plc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  ctl_cmd_t         ctl,
  output ctl_sts_t         sts,
  input  logic [1:0]       cmd,
  input  logic [OFF_W-1:0] bus_offset,
  input  logic [31:0]      write_data,
  input  logic [5:0]       source,
  input  logic             line_level,
  output logic [31:0]      read_data,
  output logic [1:0]       irq_pending
);

  // Latched transaction.
  logic [1:0]       cmd_q;
  logic [OFF_W-1:0] off_q;
  logic [31:0]      wdata_q;
  logic [5:0]       src_q;
  logic             lvl_q;

  // Architectural state.
  logic [NUM_SOURCES-1:0] level;
  logic [NUM_SOURCES-1:0] pvalid;
  logic [31:0]            en     [NUM_CONTEXTS][2];
  logic [31:0]            thr    [NUM_CONTEXTS];
  logic [SRC_W-1:0]       claimed[NUM_CONTEXTS];

  // Search state.
  logic [CNT_W-1:0] cnt;
  logic             pv;
  logic [SRC_W-1:0] ps;
  logic [31:0]      top [NUM_CONTEXTS];
  logic [SRC_W-1:0] best[NUM_CONTEXTS];

  logic [31:0]       rd_q;
  logic [1:0]        pend_q;
  logic              pv_rd;
  logic [31:0]       ram_rdata;
  logic [31:0]       prio_val;
  logic [SRC_W-1:0]  raddr;
  logic              ram_we;
  logic [31:0]       rd_val;
  dec_t              dec;

  assign dec      = decode(off_q);
  assign prio_val = pv_rd ? ram_rdata : 32'd0;
  assign raddr    = ctl.apply ? dec.prio_idx : cnt[SRC_W-1:0];
  assign ram_we   = ctl.apply && (cmd_q == CMD_WRITE) && dec.is_prio &&
                    (dec.prio_idx != '0);

  assign sts.claim_read = (cmd_q == CMD_READ) && dec.is_claim;
  assign sts.prio_read  = (cmd_q == CMD_READ) && dec.is_prio;
  assign sts.srch_done  = (cnt == CNT_W'(NUM_SOURCES)) && !pv;

  assign read_data   = rd_q;
  assign irq_pending = pend_q;

  plc_ram #(.WIDTH(32), .DEPTH(NUM_SOURCES)) u_prio_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (dec.prio_idx),
    .wdata (wdata_q),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  // Read data of the registers that live in flip-flops.
  always_comb begin
    rd_val = 32'd0;
    if (cmd_q == CMD_READ) begin
      if (dec.is_pend) begin
        rd_val = dec.pend_word ? level[63:32] : level[31:0];
      end else if (dec.is_en) begin
        rd_val = en[dec.en_ctx][dec.en_word];
      end else if (dec.is_thr) begin
        rd_val = thr[dec.ctx];
      end else if (dec.is_claim) begin
        rd_val = {{(32-SRC_W){1'b0}}, best[dec.ctx]};
      end
    end
  end

  // Transaction latch and the read-data register.
  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      cmd_q   <= cmd;
      off_q   <= bus_offset;
      wdata_q <= write_data;
      src_q   <= source;
      lvl_q   <= line_level;
    end
    if (ctl.apply) begin
      rd_q <= rd_val;
    end else if (ctl.rd_prio) begin
      rd_q <= prio_val;
    end
    pv_rd <= pvalid[raddr];
  end

  // Register writes, level changes and claim bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      level  <= '0;
      pvalid <= '0;
      pend_q <= '0;
      for (int c = 0; c < NUM_CONTEXTS; c++) begin
        en[c][0]   <= '0;
        en[c][1]   <= '0;
        thr[c]     <= '0;
        claimed[c] <= '0;
      end
    end else begin
      if (ram_we) begin
        pvalid[dec.prio_idx] <= 1'b1;
      end
      if (ctl.apply) begin
        case (cmd_q)
          CMD_READ: begin
            if (dec.is_claim) begin
              claimed[dec.ctx] <= best[dec.ctx];
            end
          end
          CMD_WRITE: begin
            if (dec.is_en) begin
              en[dec.en_ctx][dec.en_word] <= wdata_q;
            end else if (dec.is_thr) begin
              thr[dec.ctx] <= wdata_q;
            end else if (dec.is_claim &&
                         wdata_q == {{(32-SRC_W){1'b0}}, claimed[dec.ctx]}) begin
              claimed[dec.ctx] <= '0;
            end
          end
          CMD_LEVEL: begin
            if (src_q != '0 && {1'b0, src_q} < 7'(NUM_SOURCES)) begin
              level[src_q[SRC_W-1:0]] <= lvl_q;
            end
          end
          default: begin
          end
        endcase
      end
      if (ctl.pend_capture) begin
        for (int c = 0; c < 2; c++) begin
          pend_q[c] <= (c < NUM_CONTEXTS) && (best[c] != '0);
        end
      end
    end
  end

  // Serial search: one source read per cycle, compared in the cycle after its read.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= CNT_W'(NUM_SOURCES);
      pv  <= 1'b0;
    end else if (ctl.srch_init) begin
      cnt <= CNT_W'(1);
      pv  <= 1'b0;
    end else if (ctl.srch_run) begin
      if (cnt != CNT_W'(NUM_SOURCES)) begin
        cnt <= cnt + CNT_W'(1);
        pv  <= 1'b1;
      end else begin
        pv <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.srch_run) begin
      ps <= cnt[SRC_W-1:0];
    end
    for (int c = 0; c < NUM_CONTEXTS; c++) begin
      if (ctl.srch_init) begin
        top[c]  <= thr[c];
        best[c] <= '0;
      end else if (ctl.srch_run && pv && level[ps] && en[c][ps[5]][ps[4:0]] &&
                   (ps != claimed[c]) && (prio_val > top[c])) begin
        top[c]  <= prio_val;
        best[c] <= ps;
      end
    end
  end

endmodule

// File: hw/rtl/platform_interrupt_controller_core.sv
// Interrupt controller with a PLIC-style register map, level-driven sources.
//
// The request channel (req_valid / req_stall) carries one transaction per item:
// a bus read, a bus write or a change of one source line's level. The response
// channel (rsp_valid / rsp_stall) returns exactly one transaction per request
// with read_data (zero unless a read) and irq_pending, one bit per context.
// A request is taken only while the block is idle; it then stalls the request
// side until its response has been taken.
// The time from acceptance to response is set by the serial priority scan: each
// scan reads one source per cycle through the single read port of the priority
// RAM, and a claim read scans once before and once after updating the claim. A
// priority read also passes through a read wait state after the apply state.
// A new request is accepted only after the previous response has been taken.
// While the receiver stalls, the response holds steady and no new request is
// accepted. Synchronous reset clears all priorities, levels, enables,
// thresholds and claims at once and returns the block to idle.
// Depends on plc_pkg, plc_ctrl, plc_dpath and plc_ram.
module platform_interrupt_controller_core import plc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  logic [1:0]       cmd,
  input  logic [OFF_W-1:0] bus_offset,
  input  logic [31:0]      write_data,
  input  logic [5:0]       source,
  input  logic             line_level,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output logic [31:0]      read_data,
  output logic [1:0]       irq_pending
);

  ctl_cmd_t ctl;
  ctl_sts_t sts;

  plc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .sts       (sts),
    .ctl       (ctl)
  );

  plc_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .sts         (sts),
    .cmd         (cmd),
    .bus_offset  (bus_offset),
    .write_data  (write_data),
    .source      (source),
    .line_level  (line_level),
    .read_data   (read_data),
    .irq_pending (irq_pending)
  );

  // A response is only shown while requests are held off.
  a_rsp_blocks_req: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> req_stall)
    else $error("response shown while requests are accepted");

  // An accepted request is never answered in the following cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> (req_stall && !rsp_valid))
    else $error("request accepted without entering the busy phase");

  // The block leaves reset idle, with no response pending.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (!rsp_valid && !ctl.apply))
    else $error("block not idle after reset");

endmodule
